[sv/stdp_syn_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the STDP synapse update block.
// Depends on nothing; every other file of the block refers to it by scoped names.
package stdp_syn_pkg;

   localparam int DataW = 16;
   localparam int TimeW = 32;
   localparam int CsrIdxW = 3;

   // Configuration register indexes.
   localparam logic [CsrIdxW-1:0] CSR_WINDOW = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_POT_GAIN = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_DEP_GAIN = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_LEARN_RATE = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_META_GAIN = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_CONS_GAIN = 3'd5;

   localparam logic [DataW-1:0] WINDOW_RST = 16'd20;
   localparam logic [DataW-1:0] POT_GAIN_RST = 16'd410;
   localparam logic [DataW-1:0] DEP_GAIN_RST = 16'd430;
   localparam logic [DataW-1:0] LEARN_RATE_RST = 16'd655;
   localparam logic [DataW-1:0] META_GAIN_RST = 16'd66;
   localparam logic [DataW-1:0] CONS_GAIN_RST = 16'd66;

   // Commands.
   localparam logic [1:0] CMD_STDP = 2'd0;
   localparam logic [1:0] CMD_META = 2'd1;
   localparam logic [1:0] CMD_CONS = 2'd2;

   localparam logic [DataW-1:0] WEIGHT_MAX = 16'd40960;
   localparam logic [DataW-1:0] META_MAX = 16'd8192;
   localparam logic signed [16:0] ONE_Q14 = 17'sd16384;
   localparam logic [DataW-1:0] WEIGHT_HIGH = 16'd6554;
   localparam logic [DataW-1:0] WEIGHT_LOW = 16'd1638;
   localparam logic [16:0] ONE_Q16 = 17'd65536;

   // Trace: (9t + 16389) / 10 by reciprocal multiplication.
   localparam logic [19:0] TRACE_OFFSET = 20'd16389;
   localparam logic [18:0] TRACE_RCP = 19'd419431;
   localparam int TraceShift = 22;

   // Window divider.
   localparam int DivW = 33;
   localparam int QuoW = 17;

   // Exponential series.
   localparam int ExpTerms = 10;
   localparam int ExpPhases = 4;
   localparam int ExpStages = ExpTerms * ExpPhases;
   localparam int ExpWorkW = 36;
   localparam int NibPerStage = 3;
   localparam int SumW = 35;
   localparam logic [ExpWorkW-1:0] EXP_ONE = 36'h1_0000_0000;
   localparam logic signed [SumW-1:0] SUM_ONE = 35'sh1_0000_0000;

   typedef struct packed {
      logic vld;
      logic [1:0] cmd;
      logic [DataW-1:0] weight;
      logic [DataW-1:0] meta;
      logic [DataW-1:0] trace;
      logic dt_pos;
      logic in_win;
   } side_type;

   // One step of long division by a small constant: returns quotient digit and remainder.
   function automatic logic [7:0] nib_div(input logic [3:0] rem, input logic [3:0] nib,
                                          input logic [3:0] k);
      logic [7:0] v;
      logic [3:0] q;
      logic [7:0] r;
      v = {rem, nib};
      q = 4'd0;
      for (int j = 1; j < 16; j++) begin
         if (int'(v) >= j * int'(k)) q = 4'(j);
      end
      r = 8'(int'(v) - int'(q) * int'(k));
      return {q, r[3:0]};
   endfunction

endpackage

[sv/stdp_syn_aux.sv]
`timescale 1ns / 1ps
// Front stages: spike interval, trace update, metaplasticity and consolidation.
// Depends on stdp_syn_pkg.
module stdp_syn_aux (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  stdp_syn_pkg::side_type              side_i,
   input  logic signed [stdp_syn_pkg::DivW-1:0] diff_i,
   input  logic [stdp_syn_pkg::DataW-1:0]      window,
   input  logic [stdp_syn_pkg::DataW-1:0]      meta_gain,
   input  logic [stdp_syn_pkg::DataW-1:0]      cons_gain,
   output stdp_syn_pkg::side_type              side_o,
   output logic [stdp_syn_pkg::DivW-1:0]       dividend_o
);

   stdp_syn_pkg::side_type a_side_ff, a_side_in;
   logic [15:0] a_mag_ff, a_mag_in;
   logic [15:0] a_trq_ff, a_trq_in;
   logic signed [33:0] a_mprod_ff, a_mprod_in;
   logic [32:0] a_cprod_ff, a_cprod_in;
   logic a_hi_ff, a_hi_in;
   logic a_lo_ff, a_lo_in;

   stdp_syn_pkg::side_type b_side_ff, b_side_in;
   logic [32:0] b_dividend_ff, b_dividend_in;

   // Stage A: interval magnitude, window test and the three products.
   always_comb begin
      logic [32:0] mag;
      logic [19:0] tn;
      logic [38:0] tprod;
      logic signed [16:0] tdiff;
      logic [16:0] factor;
      a_side_in = side_i;
      mag = diff_i[32] ? 33'(-diff_i) : 33'(diff_i);
      a_side_in.in_win = mag < {17'd0, window};
      a_side_in.dt_pos = !diff_i[32] && (diff_i != '0);
      a_mag_in = mag[15:0];
      tn = 20'(side_i.trace) * 20'd9 + stdp_syn_pkg::TRACE_OFFSET;
      tprod = 39'(tn) * 39'(stdp_syn_pkg::TRACE_RCP);
      a_trq_in = 16'(tprod >> stdp_syn_pkg::TraceShift);
      tdiff = stdp_syn_pkg::ONE_Q14 - $signed({1'b0, side_i.trace});
      a_mprod_in = 34'(tdiff) * 34'($signed({1'b0, meta_gain}));
      a_hi_in = side_i.weight >= stdp_syn_pkg::WEIGHT_HIGH;
      a_lo_in = side_i.weight <= stdp_syn_pkg::WEIGHT_LOW;
      factor = a_hi_in ? stdp_syn_pkg::ONE_Q16 - 17'(cons_gain)
                       : stdp_syn_pkg::ONE_Q16 + 17'(cons_gain);
      a_cprod_in = 33'(side_i.meta) * 33'(factor);
   end

   // Stage B: final metaplasticity and trace values, divider dividend.
   always_comb begin
      logic [33:0] mabs;
      logic [15:0] dmag;
      logic signed [17:0] nm;
      logic [16:0] cr;
      b_side_in = a_side_ff;
      mabs = a_mprod_ff[33] ? 34'(-a_mprod_ff) : 34'(a_mprod_ff);
      dmag = 16'((mabs + 34'd131072) >> 18);
      nm = a_mprod_ff[33] ? $signed({2'b0, a_side_ff.meta}) - $signed({2'b0, dmag})
                          : $signed({2'b0, a_side_ff.meta}) + $signed({2'b0, dmag});
      cr = 17'((a_cprod_ff + 33'd32768) >> 16);
      case (a_side_ff.cmd)
         stdp_syn_pkg::CMD_STDP: begin
            b_side_in.trace = a_trq_ff;
         end
         stdp_syn_pkg::CMD_META: begin
            if (nm < 0) begin
               b_side_in.meta = '0;
            end else if (nm > $signed({2'b0, stdp_syn_pkg::META_MAX})) begin
               b_side_in.meta = stdp_syn_pkg::META_MAX;
            end else begin
               b_side_in.meta = nm[15:0];
            end
         end
         stdp_syn_pkg::CMD_CONS: begin
            if (a_hi_ff) begin
               b_side_in.meta = cr[15:0];
            end else if (a_lo_ff) begin
               b_side_in.meta = cr[16] ? 16'hFFFF : cr[15:0];
            end
         end
         default: begin
            b_side_in = a_side_ff;
         end
      endcase
      b_dividend_in = {1'b0, a_mag_ff, 16'd0} + 33'(window >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_side_ff.vld <= 1'b0;
         b_side_ff.vld <= 1'b0;
      end else if (en) begin
         a_side_ff <= a_side_in;
         b_side_ff <= b_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_mag_ff <= a_mag_in;
         a_trq_ff <= a_trq_in;
         a_mprod_ff <= a_mprod_in;
         a_cprod_ff <= a_cprod_in;
         a_hi_ff <= a_hi_in;
         a_lo_ff <= a_lo_in;
         b_dividend_ff <= b_dividend_in;
      end
   end

   assign side_o = b_side_ff;
   assign dividend_o = b_dividend_ff;

endmodule

[sv/stdp_syn_xdiv.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider: normalised interval x = round(|dt| * 2^16 / window).
// Depends on stdp_syn_pkg.
module stdp_syn_xdiv (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  stdp_syn_pkg::side_type              side_i,
   input  logic [stdp_syn_pkg::DivW-1:0]       dividend_i,
   input  logic [stdp_syn_pkg::DataW-1:0]      window,
   output stdp_syn_pkg::side_type              side_o,
   output logic [stdp_syn_pkg::DataW-1:0]      x_o
);

   typedef struct packed {
      stdp_syn_pkg::side_type side;
      logic [stdp_syn_pkg::DivW-1:0] rem;
      logic [stdp_syn_pkg::QuoW-1:0] quo;
   } div_type;

   div_type head;
   div_type pipe_ff [stdp_syn_pkg::QuoW];
   div_type pipe_in [stdp_syn_pkg::QuoW];

   always_comb begin
      head.side = side_i;
      head.rem = dividend_i;
      head.quo = '0;
   end

   for (genvar s = 0; s < stdp_syn_pkg::QuoW; s++) begin : g_stage
      localparam int B = stdp_syn_pkg::QuoW - 1 - s;
      div_type src;
      if (s == 0) begin : g_first
         assign src = head;
      end else begin : g_next
         assign src = pipe_ff[s-1];
      end

      always_comb begin
         logic [stdp_syn_pkg::DivW-1:0] dv;
         pipe_in[s] = src;
         dv = stdp_syn_pkg::DivW'(window) << B;
         if (src.rem >= dv) begin
            pipe_in[s].rem = src.rem - dv;
            pipe_in[s].quo[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_ff[s].side.vld <= 1'b0;
         end else if (en) begin
            pipe_ff[s] <= pipe_in[s];
         end
      end
   end

   assign side_o = pipe_ff[stdp_syn_pkg::QuoW-1].side;
   assign x_o = pipe_ff[stdp_syn_pkg::QuoW-1].quo[stdp_syn_pkg::QuoW-1] ? '1
                : pipe_ff[stdp_syn_pkg::QuoW-1].quo[stdp_syn_pkg::DataW-1:0];

endmodule

[sv/stdp_syn_exp.sv]
`timescale 1ns / 1ps
// Pipelined Taylor series for exp(-x): per term one multiply stage and three
// long-division stages by the term index. Depends on stdp_syn_pkg.
module stdp_syn_exp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  stdp_syn_pkg::side_type               side_i,
   input  logic [stdp_syn_pkg::DataW-1:0]       x_i,
   output stdp_syn_pkg::side_type               side_o,
   output logic signed [stdp_syn_pkg::SumW-1:0] sum_o
);

   typedef struct packed {
      stdp_syn_pkg::side_type side;
      logic [stdp_syn_pkg::DataW-1:0] x;
      logic [stdp_syn_pkg::ExpWorkW-1:0] work;
      logic [3:0] rem;
      logic signed [stdp_syn_pkg::SumW-1:0] sum;
   } exp_type;

   exp_type head;
   exp_type pipe_ff [stdp_syn_pkg::ExpStages];
   exp_type pipe_in [stdp_syn_pkg::ExpStages];

   always_comb begin
      head.side = side_i;
      head.x = x_i;
      head.work = stdp_syn_pkg::EXP_ONE;
      head.rem = '0;
      head.sum = stdp_syn_pkg::SUM_ONE;
   end

   for (genvar s = 0; s < stdp_syn_pkg::ExpStages; s++) begin : g_stage
      localparam int K = s / stdp_syn_pkg::ExpPhases + 1;
      localparam int Ph = s % stdp_syn_pkg::ExpPhases;
      localparam int Half = K / 2;
      localparam bit Odd = (K % 2) == 1;
      exp_type src;
      if (s == 0) begin : g_first
         assign src = head;
      end else begin : g_next
         assign src = pipe_ff[s-1];
      end

      always_comb begin
         logic [48:0] prod;
         logic [32:0] rnd;
         logic [7:0] dr;
         int hi;
         pipe_in[s] = src;
         prod = '0;
         rnd = '0;
         dr = '0;
         hi = 0;
         if (Ph == 0) begin
            // Next term before the division, rounded, plus half the divisor.
            prod = 49'(src.work[32:0]) * 49'(src.x);
            rnd = 33'((prod + 49'd32768) >> 16);
            pipe_in[s].work = 36'(rnd) + 36'(Half);
            pipe_in[s].rem = '0;
         end else begin
            for (int j = 0; j < stdp_syn_pkg::NibPerStage; j++) begin
               hi = stdp_syn_pkg::ExpWorkW - 1 - 4 * ((Ph - 1) * stdp_syn_pkg::NibPerStage + j);
               dr = stdp_syn_pkg::nib_div(pipe_in[s].rem, pipe_in[s].work[hi -: 4], 4'(K));
               pipe_in[s].work[hi -: 4] = dr[7:4];
               pipe_in[s].rem = dr[3:0];
            end
            if (Ph == stdp_syn_pkg::ExpPhases - 1) begin
               if (Odd) begin
                  pipe_in[s].sum = src.sum - $signed({1'b0, pipe_in[s].work[33:0]});
               end else begin
                  pipe_in[s].sum = src.sum + $signed({1'b0, pipe_in[s].work[33:0]});
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_ff[s].side.vld <= 1'b0;
         end else if (en) begin
            pipe_ff[s] <= pipe_in[s];
         end
      end
   end

   assign side_o = pipe_ff[stdp_syn_pkg::ExpStages-1].side;
   assign sum_o = pipe_ff[stdp_syn_pkg::ExpStages-1].sum;

endmodule

[sv/stdp_synapse_update.sv]
`timescale 1ns / 1ps
// STDP synapse update, top level. One item is accepted every cycle unless the
// result side stalls. Most of the pipeline is the 17-stage window divider and
// the 40-stage exp series. Synchronous active-high reset empties the pipeline
// and loads register defaults. Depends on stdp_syn_pkg, stdp_syn_aux,
// stdp_syn_xdiv and stdp_syn_exp.
module stdp_synapse_update (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_cmd,
   input  logic [stdp_syn_pkg::TimeW-1:0]       req_pre_time,
   input  logic [stdp_syn_pkg::TimeW-1:0]       req_post_time,
   input  logic [stdp_syn_pkg::DataW-1:0]       req_weight_in,
   input  logic [stdp_syn_pkg::DataW-1:0]       req_meta_in,
   input  logic [stdp_syn_pkg::DataW-1:0]       req_trace_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [stdp_syn_pkg::DataW-1:0]       rsp_weight_out,
   output logic [stdp_syn_pkg::DataW-1:0]       rsp_meta_out,
   output logic [stdp_syn_pkg::DataW-1:0]       rsp_trace_out,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [stdp_syn_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [stdp_syn_pkg::DataW-1:0]       csr_data
);

   // Configuration registers. Writes are always accepted; an unknown index is ignored.
   logic [15:0] window_ff, pot_gain_ff, dep_gain_ff, rate_ff, meta_gain_ff, cons_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= stdp_syn_pkg::WINDOW_RST;
         pot_gain_ff <= stdp_syn_pkg::POT_GAIN_RST;
         dep_gain_ff <= stdp_syn_pkg::DEP_GAIN_RST;
         rate_ff <= stdp_syn_pkg::LEARN_RATE_RST;
         meta_gain_ff <= stdp_syn_pkg::META_GAIN_RST;
         cons_gain_ff <= stdp_syn_pkg::CONS_GAIN_RST;
      end else if (csr_valid) begin
         case (csr_index)
            stdp_syn_pkg::CSR_WINDOW: window_ff <= csr_data;
            stdp_syn_pkg::CSR_POT_GAIN: pot_gain_ff <= csr_data;
            stdp_syn_pkg::CSR_DEP_GAIN: dep_gain_ff <= csr_data;
            stdp_syn_pkg::CSR_LEARN_RATE: rate_ff <= csr_data;
            stdp_syn_pkg::CSR_META_GAIN: meta_gain_ff <= csr_data;
            stdp_syn_pkg::CSR_CONS_GAIN: cons_gain_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // The whole pipeline moves as one. It advances whenever the output register
   // is empty or its result is being transferred, so an item can enter every
   // cycle while results flow out.
   stdp_syn_pkg::side_type o_side_ff, o_side_in;
   logic en;

   assign en = !o_side_ff.vld || rsp_ready;
   assign req_ready = en;

   // Stage 1: register the item and form the exact signed spike interval.
   stdp_syn_pkg::side_type s1_side_ff, s1_side_in;
   logic signed [stdp_syn_pkg::DivW-1:0] s1_diff_ff, s1_diff_in;

   always_comb begin
      s1_side_in.vld = req_valid;
      s1_side_in.cmd = req_cmd;
      s1_side_in.weight = req_weight_in;
      s1_side_in.meta = req_meta_in;
      s1_side_in.trace = req_trace_in;
      s1_side_in.dt_pos = 1'b0;
      s1_side_in.in_win = 1'b0;
      s1_diff_in = $signed({1'b0, req_post_time}) - $signed({1'b0, req_pre_time});
   end

   // Metaplasticity, consolidation and trace are settled in these two stages;
   // they then ride alongside the weight path unchanged.
   stdp_syn_pkg::side_type aux_side;
   logic [stdp_syn_pkg::DivW-1:0] aux_dividend;

   stdp_syn_aux u_aux (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .side_i     (s1_side_ff),
      .diff_i     (s1_diff_ff),
      .window     (window_ff),
      .meta_gain  (meta_gain_ff),
      .cons_gain  (cons_gain_ff),
      .side_o     (aux_side),
      .dividend_o (aux_dividend)
   );

   stdp_syn_pkg::side_type div_side;
   logic [stdp_syn_pkg::DataW-1:0] div_x;

   stdp_syn_xdiv u_xdiv (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .side_i     (aux_side),
      .dividend_i (aux_dividend),
      .window     (window_ff),
      .side_o     (div_side),
      .x_o        (div_x)
   );

   stdp_syn_pkg::side_type exp_side;
   logic signed [stdp_syn_pkg::SumW-1:0] exp_sum;

   stdp_syn_exp u_exp (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .side_i (div_side),
      .x_i    (div_x),
      .side_o (exp_side),
      .sum_o  (exp_sum)
   );

   // Tail: round the series to Q1.16, then scale by gain, meta and learning rate,
   // one multiplier per stage.
   stdp_syn_pkg::side_type t0_side_ff, t1_side_ff, t2_side_ff, t3_side_ff;
   logic [16:0] t0_e_ff, t0_e_in;
   logic [20:0] t1_m_ff, t1_m_in;
   logic [36:0] t2_mm_ff, t2_mm_in;
   logic [52:0] t3_prod_ff, t3_prod_in;

   always_comb begin
      logic [33:0] rsum;
      logic [15:0] gain;
      logic [32:0] gprod;
      rsum = 34'(exp_sum) + 34'd32768;
      t0_e_in = exp_sum[stdp_syn_pkg::SumW-1] ? '0 : 17'(rsum >> 16);
      gain = t0_side_ff.dt_pos ? pot_gain_ff : dep_gain_ff;
      gprod = 33'(gain) * 33'(t0_e_ff);
      t1_m_in = 21'((34'(gprod) + 34'd2048) >> 12);
      t2_mm_in = 37'(t1_m_ff) * 37'(t1_side_ff.meta);
      t3_prod_in = 53'(t2_mm_ff) * 53'(rate_ff);
   end

   // Final stage: round the change to Q3.13, apply it and clamp the weight to 0..5.0.
   // Commands other than the STDP update leave the weight as it came in.
   always_comb begin
      logic [53:0] dsum;
      logic [21:0] delta;
      logic signed [23:0] nw;
      o_side_in = t3_side_ff;
      dsum = 54'(t3_prod_ff) + (54'd1 << 30);
      delta = 22'(dsum >> 31);
      nw = $signed({8'd0, t3_side_ff.weight});
      if (t3_side_ff.in_win) begin
         if (t3_side_ff.dt_pos) begin
            nw = nw + $signed({2'b0, delta});
         end else begin
            nw = nw - $signed({2'b0, delta});
         end
      end
      if (t3_side_ff.cmd == stdp_syn_pkg::CMD_STDP) begin
         if (nw < 0) begin
            o_side_in.weight = '0;
         end else if (nw > $signed({8'd0, stdp_syn_pkg::WEIGHT_MAX})) begin
            o_side_in.weight = stdp_syn_pkg::WEIGHT_MAX;
         end else begin
            o_side_in.weight = nw[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff.vld <= 1'b0;
         t0_side_ff.vld <= 1'b0;
         t1_side_ff.vld <= 1'b0;
         t2_side_ff.vld <= 1'b0;
         t3_side_ff.vld <= 1'b0;
         o_side_ff.vld <= 1'b0;
      end else if (en) begin
         s1_side_ff <= s1_side_in;
         t0_side_ff <= exp_side;
         t1_side_ff <= t0_side_ff;
         t2_side_ff <= t1_side_ff;
         t3_side_ff <= t2_side_ff;
         o_side_ff <= o_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_diff_ff <= s1_diff_in;
         t0_e_ff <= t0_e_in;
         t1_m_ff <= t1_m_in;
         t2_mm_ff <= t2_mm_in;
         t3_prod_ff <= t3_prod_in;
      end
   end

   assign rsp_valid = o_side_ff.vld;
   assign rsp_weight_out = o_side_ff.weight;
   assign rsp_meta_out = o_side_ff.meta;
   assign rsp_trace_out = o_side_ff.trace;

endmodule
